FILE: sv/idq_pkg.sv
// Shared types, sizes and helpers for the indexed double-ended queue.
// Used by the queue core and its testbench; depends on nothing.
package idq_pkg;

    // Storage geometry
    localparam int DEPTH      = 16;
    localparam int WORD_BITS  = 32;
    localparam int ADDR_BITS  = $clog2(DEPTH);
    localparam int SUM_BITS   = ADDR_BITS + 1;
    localparam int COUNT_BITS = $clog2(DEPTH + 1);

    // Fixed beat field widths
    localparam int CMD_BITS   = 3;
    localparam int POS_BITS   = 5;
    localparam int VALUE_BITS = 32;
    localparam int FILL_BITS  = 5;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_ADD_FRONT    = 3'd0,
        CMD_ADD_BACK     = 3'd1,
        CMD_REMOVE_FRONT = 3'd2,
        CMD_REMOVE_BACK  = 3'd3,
        CMD_READ_AT      = 3'd4,
        CMD_WRITE_AT     = 3'd5,
        CMD_INSERT_AT    = 3'd6
    } command_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    typedef struct packed {
        command_t                command;
        logic [POS_BITS-1:0]     position;
        logic [VALUE_BITS-1:0]   value;
    } request_t;

    typedef struct packed {
        logic [VALUE_BITS-1:0]   read_value;
        status_t                 status;
        logic [FILL_BITS-1:0]    fill_count;
    } result_t;

    // Slot of an entry: base plus offset, wrapped once around the store
    function automatic logic [ADDR_BITS-1:0] slot_of(
        input logic [ADDR_BITS-1:0] base,
        input logic [ADDR_BITS-1:0] offset
    );
        logic [SUM_BITS-1:0] sum;
        sum = {1'b0, base} + {1'b0, offset};
        if (sum >= SUM_BITS'(DEPTH))
        begin
            sum = sum - SUM_BITS'(DEPTH);
        end
        return sum[ADDR_BITS-1:0];
    endfunction

    // Keep the low WORD_BITS of a beat value
    function automatic logic [WORD_BITS-1:0] to_word(input logic [VALUE_BITS-1:0] v);
        logic [VALUE_BITS+WORD_BITS-1:0] w;
        w = {{WORD_BITS{1'b0}}, v};
        return w[WORD_BITS-1:0];
    endfunction

    // Zero-extend or trim a stored word to the beat value width
    function automatic logic [VALUE_BITS-1:0] from_word(input logic [WORD_BITS-1:0] d);
        logic [VALUE_BITS+WORD_BITS-1:0] w;
        w = {{VALUE_BITS{1'b0}}, d};
        return w[VALUE_BITS-1:0];
    endfunction

endpackage

FILE: sv/idq_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Standalone; no package dependency.
module idq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: sv/indexed_double_ended_queue_core.sv
// Indexed double-ended queue core: control sequencer around the entry RAM.
// Depends on idq_pkg (types, sizes, slot arithmetic) and idq_ram.
//
// Usage
//   Command channel: drive request (command, position, value) and raise start.
//   A beat is taken at a rising edge where start is high and busy is low.
//   Result channel: done is high for exactly one cycle and result carries
//   read_value, status and fill_count for that beat. The receiver cannot
//   stall it; a result is taken at the edge that ends its done cycle.
// Latency and throughput
//   Every command but insert gives its result in the cycle after it is
//   taken and busy stays low, so such commands run one per cycle. Reads are
//   issued to the RAM at the accept edge and the RAM's output register
//   feeds read_value directly during the done cycle.
//   Insert at the back finishes like a write. Insert with K entries behind
//   the position walks them through the single RAM port pair, one entry a
//   cycle, then writes the new word: busy is high through the walk and the
//   write, and done is registered from the write state.
// Reset
//   rst_n clears the front pointer, the count and the sequencer; the entry
//   store is not cleared (only held entries are ever read).
module indexed_double_ended_queue_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  idq_pkg::request_t request,
    output logic              done,
    output idq_pkg::result_t  result
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SHIFT,
        S_FINISH
    } state_t;

    // Control state
    state_t                            state_reg, state_next;
    logic [idq_pkg::ADDR_BITS-1:0]     front_reg, front_next;
    logic [idq_pkg::COUNT_BITS-1:0]    count_reg, count_next;
    logic                              done_reg, done_next;
    logic                              rd_sel_reg, rd_sel_next;

    // Insert walk and result payload
    logic [idq_pkg::ADDR_BITS-1:0]     idx_reg, idx_next;
    logic [idq_pkg::ADDR_BITS-1:0]     ins_pos_reg, ins_pos_next;
    logic [idq_pkg::WORD_BITS-1:0]     ins_word_reg, ins_word_next;
    idq_pkg::status_t                  status_reg, status_next;
    logic [idq_pkg::COUNT_BITS-1:0]    fill_reg, fill_next;

    // RAM port
    logic                              ram_we;
    logic [idq_pkg::ADDR_BITS-1:0]     ram_waddr;
    logic [idq_pkg::WORD_BITS-1:0]     ram_wdata;
    logic                              ram_re;
    logic [idq_pkg::ADDR_BITS-1:0]     ram_raddr;
    logic [idq_pkg::WORD_BITS-1:0]     ram_rdata;

    // Decode helpers
    logic [idq_pkg::ADDR_BITS-1:0]     pos_a;
    logic [idq_pkg::ADDR_BITS-1:0]     count_a;
    logic [idq_pkg::ADDR_BITS-1:0]     slot_pos;
    logic [idq_pkg::ADDR_BITS-1:0]     slot_cnt;
    logic [idq_pkg::ADDR_BITS-1:0]     slot_last;
    logic [idq_pkg::ADDR_BITS-1:0]     slot_next_front;
    logic [idq_pkg::ADDR_BITS-1:0]     front_dec;
    logic [idq_pkg::WORD_BITS-1:0]     in_word;
    logic                              is_full;
    logic                              is_empty;
    logic                              pos_lt_cnt;
    logic                              pos_le_cnt;
    logic                              pos_eq_cnt;

    idq_ram #(
        .WIDTH (idq_pkg::WORD_BITS),
        .DEPTH (idq_pkg::DEPTH)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Positions are only used as slot offsets once they are known to be in range,
    // so truncating to the address width is safe there.
    assign pos_a    = idq_pkg::ADDR_BITS'(request.position);
    assign count_a  = idq_pkg::ADDR_BITS'(count_reg);
    assign in_word  = idq_pkg::to_word(request.value);

    assign slot_pos        = idq_pkg::slot_of(front_reg, pos_a);
    assign slot_cnt        = idq_pkg::slot_of(front_reg, count_a);
    assign slot_last       = idq_pkg::slot_of(front_reg, count_a - 1'b1);
    assign slot_next_front = idq_pkg::slot_of(front_reg, idq_pkg::ADDR_BITS'(1));
    assign front_dec       = (front_reg == '0) ? idq_pkg::ADDR_BITS'(idq_pkg::DEPTH - 1)
                                               : front_reg - 1'b1;

    assign is_full    = (count_reg == idq_pkg::COUNT_BITS'(idq_pkg::DEPTH));
    assign is_empty   = (count_reg == '0);
    assign pos_lt_cnt = (32'(request.position) <  32'(count_reg));
    assign pos_le_cnt = (32'(request.position) <= 32'(count_reg));
    assign pos_eq_cnt = (32'(request.position) == 32'(count_reg));

    always_comb
    begin
        state_next    = state_reg;
        front_next    = front_reg;
        count_next    = count_reg;
        done_next     = 1'b0;
        rd_sel_next   = 1'b0;
        idx_next      = idx_reg;
        ins_pos_next  = ins_pos_reg;
        ins_word_next = ins_word_reg;
        status_next   = idq_pkg::ST_OK;

        ram_we    = 1'b0;
        ram_waddr = slot_pos;
        ram_wdata = in_word;
        ram_re    = 1'b0;
        ram_raddr = slot_pos;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    done_next = 1'b1;
                    case (request.command)
                        idq_pkg::CMD_ADD_FRONT:
                        begin
                            if (is_full)
                            begin
                                status_next = idq_pkg::ST_FULL;
                            end
                            else
                            begin
                                ram_we     = 1'b1;
                                ram_waddr  = front_dec;
                                front_next = front_dec;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        idq_pkg::CMD_ADD_BACK:
                        begin
                            if (is_full)
                            begin
                                status_next = idq_pkg::ST_FULL;
                            end
                            else
                            begin
                                ram_we     = 1'b1;
                                ram_waddr  = slot_cnt;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        idq_pkg::CMD_REMOVE_FRONT:
                        begin
                            if (is_empty)
                            begin
                                status_next = idq_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                ram_re      = 1'b1;
                                ram_raddr   = front_reg;
                                rd_sel_next = 1'b1;
                                front_next  = slot_next_front;
                                count_next  = count_reg - 1'b1;
                            end
                        end
                        idq_pkg::CMD_REMOVE_BACK:
                        begin
                            if (is_empty)
                            begin
                                status_next = idq_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                ram_re      = 1'b1;
                                ram_raddr   = slot_last;
                                rd_sel_next = 1'b1;
                                count_next  = count_reg - 1'b1;
                            end
                        end
                        idq_pkg::CMD_READ_AT:
                        begin
                            if (!pos_lt_cnt)
                            begin
                                status_next = idq_pkg::ST_RANGE;
                            end
                            else
                            begin
                                ram_re      = 1'b1;
                                ram_raddr   = slot_pos;
                                rd_sel_next = 1'b1;
                            end
                        end
                        idq_pkg::CMD_WRITE_AT:
                        begin
                            if (!pos_lt_cnt)
                            begin
                                status_next = idq_pkg::ST_RANGE;
                            end
                            else
                            begin
                                ram_we    = 1'b1;
                                ram_waddr = slot_pos;
                            end
                        end
                        idq_pkg::CMD_INSERT_AT:
                        begin
                            if (!pos_le_cnt)
                            begin
                                status_next = idq_pkg::ST_RANGE;
                            end
                            else if (is_full)
                            begin
                                status_next = idq_pkg::ST_FULL;
                            end
                            else if (pos_eq_cnt)
                            begin
                                // Insert at the back: a plain append
                                ram_we     = 1'b1;
                                ram_waddr  = slot_cnt;
                                count_next = count_reg + 1'b1;
                            end
                            else
                            begin
                                // Start the walk: fetch the last entry, it moves to count
                                done_next     = 1'b0;
                                ram_re        = 1'b1;
                                ram_raddr     = slot_last;
                                idx_next      = count_a;
                                ins_pos_next  = pos_a;
                                ins_word_next = in_word;
                                state_next    = S_SHIFT;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            S_SHIFT:
            begin
                // Drop the fetched entry one place back; fetch the next one down
                ram_we    = 1'b1;
                ram_waddr = idq_pkg::slot_of(front_reg, idx_reg);
                ram_wdata = ram_rdata;
                if ((idx_reg - 1'b1) == ins_pos_reg)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    ram_re    = 1'b1;
                    ram_raddr = idq_pkg::slot_of(front_reg, idx_reg - 2'd2);
                    idx_next  = idx_reg - 1'b1;
                end
            end

            S_FINISH:
            begin
                ram_we     = 1'b1;
                ram_waddr  = idq_pkg::slot_of(front_reg, ins_pos_reg);
                ram_wdata  = ins_word_reg;
                count_next = count_reg + 1'b1;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        fill_next = count_next;
    end

    // Sequencer state, pointers, walk bookkeeping and the registered result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            front_reg    <= '0;
            count_reg    <= '0;
            done_reg     <= 1'b0;
            rd_sel_reg   <= 1'b0;
            idx_reg      <= '0;
            ins_pos_reg  <= '0;
            ins_word_reg <= '0;
            status_reg   <= idq_pkg::ST_OK;
            fill_reg     <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            front_reg    <= front_next;
            count_reg    <= count_next;
            done_reg     <= done_next;
            rd_sel_reg   <= rd_sel_next;
            idx_reg      <= idx_next;
            ins_pos_reg  <= ins_pos_next;
            ins_word_reg <= ins_word_next;
            status_reg   <= status_next;
            fill_reg     <= fill_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

    always_comb
    begin
        result.read_value = rd_sel_reg ? idq_pkg::from_word(ram_rdata) : '0;
        result.status     = status_reg;
        result.fill_count = idq_pkg::FILL_BITS'(fill_reg);
    end

    // Count never exceeds capacity
    assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= idq_pkg::DEPTH)
    else $error("entry count above capacity");

    // Count moves by at most one entry per cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (count_reg == $past(count_reg)) ||
                 (count_reg == $past(count_reg) + 1'b1) ||
                 (count_reg == $past(count_reg) - 1'b1))
    else $error("entry count jumped");

    // A reported count matches the held count
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (32'(result.fill_count) == 32'(count_reg)))
    else $error("result count differs from held count");

    // An empty status always reports an empty queue and no word
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status == idq_pkg::ST_EMPTY) |->
            (result.fill_count == '0 && result.read_value == '0))
    else $error("empty status with entries or data");

    // No result strobe while an insert walk is moving entries
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SHIFT) |-> !done_reg)
    else $error("result strobe during insert walk");

endmodule

FILE: test/tb_indexed_double_ended_queue_core.sv
// Self-checking testbench for indexed_double_ended_queue_core.
// Depends on idq_pkg for the request/result beat types, command and status codes
// and the store geometry.
module tb_indexed_double_ended_queue_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RESET_CYCLES = 8;
    // Longest insert walks every held entry, then writes, then answers
    localparam int SETTLE_CYCLES = idq_pkg::DEPTH + 4;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    idq_pkg::request_t request = '0;
    logic              done;
    idq_pkg::result_t  result;

    indexed_double_ended_queue_core u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    always #5 clk = ~clk;

    // Command beats waiting to be driven, and the results the queue must return
    idq_pkg::request_t command_backlog[$];
    idq_pkg::result_t  predicted_results[$];

    // Shadow copy of the queue contents, advanced once per accepted command
    logic [idq_pkg::WORD_BITS-1:0] held_words [idq_pkg::DEPTH];
    logic [idq_pkg::ADDR_BITS-1:0] head_slot = '0;
    int unsigned                   held_count = 0;

    // Fill level as seen by the stimulus generator (runs ahead of the DUT)
    int unsigned gen_fill = 0;

    int  idle_pct = 0;
    logic beat_taken = 1'b0;
    int  commands_queued = 0;
    int  commands_taken = 0;
    int  results_checked = 0;
    int  mismatch_count = 0;
    int  status_seen [4] = '{0, 0, 0, 0};
    int  peak_fill = 0;

    task automatic report_mismatch(input string what);
        $display("[%0t] MISMATCH: %s", $realtime, what);
        mismatch_count++;
    endtask

    // Slot of the entry at a given offset from the front
    function automatic logic [idq_pkg::ADDR_BITS-1:0] slot_at(input int unsigned offset);
        return idq_pkg::ADDR_BITS'((int'(head_slot) + offset) % idq_pkg::DEPTH);
    endfunction

    // Apply one command to the shadow queue and return the result it must give
    task automatic predict_result(input idq_pkg::request_t cmd,
                                  output idq_pkg::result_t res);
        logic [idq_pkg::WORD_BITS-1:0] word_out;
        idq_pkg::status_t              st;
        int unsigned                   pos;
        word_out = '0;
        st       = idq_pkg::ST_OK;
        pos      = 32'(cmd.position);
        case (cmd.command)
            idq_pkg::CMD_ADD_FRONT:
            begin
                if (held_count >= idq_pkg::DEPTH)
                begin
                    st = idq_pkg::ST_FULL;
                end
                else
                begin
                    head_slot = idq_pkg::ADDR_BITS'((int'(head_slot) + idq_pkg::DEPTH - 1)
                                                    % idq_pkg::DEPTH);
                    held_words[head_slot] = cmd.value;
                    held_count++;
                end
            end
            idq_pkg::CMD_ADD_BACK:
            begin
                if (held_count >= idq_pkg::DEPTH)
                begin
                    st = idq_pkg::ST_FULL;
                end
                else
                begin
                    held_words[slot_at(held_count)] = cmd.value;
                    held_count++;
                end
            end
            idq_pkg::CMD_REMOVE_FRONT:
            begin
                if (held_count == 0)
                begin
                    st = idq_pkg::ST_EMPTY;
                end
                else
                begin
                    word_out  = held_words[head_slot];
                    head_slot = slot_at(1);
                    held_count--;
                end
            end
            idq_pkg::CMD_REMOVE_BACK:
            begin
                if (held_count == 0)
                begin
                    st = idq_pkg::ST_EMPTY;
                end
                else
                begin
                    word_out = held_words[slot_at(held_count - 1)];
                    held_count--;
                end
            end
            idq_pkg::CMD_READ_AT:
            begin
                if (pos >= held_count)
                    st = idq_pkg::ST_RANGE;
                else
                    word_out = held_words[slot_at(pos)];
            end
            idq_pkg::CMD_WRITE_AT:
            begin
                if (pos >= held_count)
                    st = idq_pkg::ST_RANGE;
                else
                    held_words[slot_at(pos)] = cmd.value;
            end
            idq_pkg::CMD_INSERT_AT:
            begin
                // Range is judged before fullness
                if (pos > held_count)
                begin
                    st = idq_pkg::ST_RANGE;
                end
                else if (held_count >= idq_pkg::DEPTH)
                begin
                    st = idq_pkg::ST_FULL;
                end
                else
                begin
                    for (int unsigned i = held_count; i > pos; i--)
                        held_words[slot_at(i)] = held_words[slot_at(i - 1)];
                    held_words[slot_at(pos)] = cmd.value;
                    held_count++;
                end
            end
            default:
            begin
            end
        endcase
        res.read_value = word_out;
        res.status     = st;
        res.fill_count = idq_pkg::FILL_BITS'(held_count);
    endtask

    // Append one command to the backlog; track the fill level it leads to
    task automatic queue_command(input idq_pkg::command_t c, input int unsigned pos,
                                 input logic [idq_pkg::VALUE_BITS-1:0] v);
        idq_pkg::request_t cmd;
        cmd.command  = c;
        cmd.position = idq_pkg::POS_BITS'(pos);
        cmd.value    = v;
        command_backlog.push_back(cmd);
        commands_queued++;
        case (c)
            idq_pkg::CMD_ADD_FRONT, idq_pkg::CMD_ADD_BACK:
                if (gen_fill < idq_pkg::DEPTH) gen_fill++;
            idq_pkg::CMD_REMOVE_FRONT, idq_pkg::CMD_REMOVE_BACK:
                if (gen_fill > 0) gen_fill--;
            idq_pkg::CMD_INSERT_AT:
                if (pos <= gen_fill && gen_fill < idq_pkg::DEPTH) gen_fill++;
            default:
            begin
            end
        endcase
    endtask

    // Random command mix: a growing or shrinking bias so the queue swings
    // between empty and full, with mostly in-range positions
    task automatic queue_random_commands(input int n);
        bit                             grow;
        int                             roll;
        idq_pkg::command_t              c;
        int unsigned                    pos;
        logic [idq_pkg::VALUE_BITS-1:0] v;
        grow = 1'b1;
        repeat (n)
        begin
            if (gen_fill == idq_pkg::DEPTH && $urandom_range(0, 3) == 0) grow = 1'b0;
            if (gen_fill == 0 && $urandom_range(0, 3) == 0) grow = 1'b1;
            if ($urandom_range(0, 49) == 0) grow = ~grow;

            roll = $urandom_range(0, 99);
            if (grow)
            begin
                if (roll < 20)      c = idq_pkg::CMD_ADD_FRONT;
                else if (roll < 40) c = idq_pkg::CMD_ADD_BACK;
                else if (roll < 60) c = idq_pkg::CMD_INSERT_AT;
                else if (roll < 70) c = idq_pkg::CMD_REMOVE_FRONT;
                else if (roll < 75) c = idq_pkg::CMD_REMOVE_BACK;
                else if (roll < 88) c = idq_pkg::CMD_READ_AT;
                else                c = idq_pkg::CMD_WRITE_AT;
            end
            else
            begin
                if (roll < 8)       c = idq_pkg::CMD_ADD_FRONT;
                else if (roll < 16) c = idq_pkg::CMD_ADD_BACK;
                else if (roll < 26) c = idq_pkg::CMD_INSERT_AT;
                else if (roll < 51) c = idq_pkg::CMD_REMOVE_FRONT;
                else if (roll < 76) c = idq_pkg::CMD_REMOVE_BACK;
                else if (roll < 88) c = idq_pkg::CMD_READ_AT;
                else                c = idq_pkg::CMD_WRITE_AT;
            end

            if ($urandom_range(0, 99) < 15)
                pos = $urandom_range(0, idq_pkg::DEPTH);
            else if (c == idq_pkg::CMD_INSERT_AT)
                pos = $urandom_range(0, gen_fill);
            else
                pos = (gen_fill == 0) ? 0 : $urandom_range(0, gen_fill - 1);

            roll = $urandom_range(0, 19);
            if (roll == 0)      v = '0;
            else if (roll == 1) v = '1;
            else                v = $urandom();

            queue_command(c, pos, v);
        end
    endtask

    // Driver: present a new beat at the falling edge once the previous one was
    // taken (or start is low); hold the beat while busy keeps it off
    always @(negedge clk)
    begin
        if (rst_n && (!start || beat_taken))
        begin
            if (command_backlog.size() != 0 && $urandom_range(0, 99) >= idle_pct)
            begin
                start   <= 1'b1;
                request <= command_backlog.pop_front();
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: at each rising edge check the result beat against the oldest
    // prediction, then predict for a command beat taken at this same edge
    always @(posedge clk)
    begin : monitor
        idq_pkg::result_t want;
        idq_pkg::result_t fresh;
        beat_taken <= rst_n && start && !busy;
        if (rst_n)
        begin
            if (done)
            begin
                if (predicted_results.size() == 0)
                begin
                    report_mismatch("result beat with no command outstanding");
                end
                else
                begin
                    want = predicted_results.pop_front();
                    results_checked++;
                    if (result.read_value !== want.read_value)
                        report_mismatch($sformatf("read_value %h, expected %h",
                                                  result.read_value, want.read_value));
                    if (result.status !== want.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  result.status, want.status));
                    if (result.fill_count !== want.fill_count)
                        report_mismatch($sformatf("fill_count %0d, expected %0d",
                                                  result.fill_count, want.fill_count));
                end
            end
            if (start && !busy)
            begin
                predict_result(request, fresh);
                predicted_results.push_back(fresh);
                commands_taken++;
                status_seen[fresh.status]++;
                if (int'(fresh.fill_count) > peak_fill) peak_fill = int'(fresh.fill_count);
            end
        end
    end

    // Wait until every queued command was taken and answered
    task automatic drain_commands();
        while (commands_taken != commands_queued || predicted_results.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: underflow/overflow/range cases on an empty and a full queue
        idle_pct = 0;
        queue_command(idq_pkg::CMD_REMOVE_FRONT, 0, '0);
        queue_command(idq_pkg::CMD_REMOVE_BACK, 0, '0);
        queue_command(idq_pkg::CMD_READ_AT, 0, '0);
        queue_command(idq_pkg::CMD_WRITE_AT, 0, $urandom());
        queue_command(idq_pkg::CMD_INSERT_AT, 1, $urandom());     // beyond the back
        queue_command(idq_pkg::CMD_INSERT_AT, 0, '1);             // into an empty queue
        queue_command(idq_pkg::CMD_ADD_FRONT, 0, '0);
        queue_command(idq_pkg::CMD_ADD_BACK, 0, 32'hA5A5_A5A5);
        queue_command(idq_pkg::CMD_INSERT_AT, 3, 32'h5A5A_5A5A);  // at the back
        queue_command(idq_pkg::CMD_INSERT_AT, 1, $urandom());     // in the middle
        queue_command(idq_pkg::CMD_WRITE_AT, 4, $urandom());
        queue_command(idq_pkg::CMD_READ_AT, 4, '0);               // last entry
        queue_command(idq_pkg::CMD_READ_AT, 5, '0);               // one past the last
        queue_command(idq_pkg::CMD_INSERT_AT, 0, $urandom());     // shifts every entry
        while (gen_fill < idq_pkg::DEPTH)
            queue_command(idq_pkg::CMD_INSERT_AT, $urandom_range(0, gen_fill), $urandom());
        queue_command(idq_pkg::CMD_ADD_FRONT, 0, $urandom());
        queue_command(idq_pkg::CMD_ADD_BACK, 0, $urandom());
        queue_command(idq_pkg::CMD_INSERT_AT, idq_pkg::DEPTH, $urandom()); // full, at back
        queue_command(idq_pkg::CMD_READ_AT, idq_pkg::DEPTH - 1, '0);
        queue_command(idq_pkg::CMD_READ_AT, idq_pkg::DEPTH, '0);
        queue_command(idq_pkg::CMD_REMOVE_BACK, 0, '0);
        queue_command(idq_pkg::CMD_REMOVE_FRONT, 0, '0);
        drain_commands();

        // Random phases with different sender gaps
        idle_pct = 0;
        queue_random_commands(320);
        drain_commands();
        idle_pct = 77;
        queue_random_commands(300);
        drain_commands();
        idle_pct = 21;
        queue_random_commands(300);
        drain_commands();
        idle_pct = 0;
        queue_random_commands(300);
        drain_commands();

        // Let any stray result beat show up
        repeat (SETTLE_CYCLES) @(negedge clk);

        $display("Ran %0d commands, checked %0d results; peak fill %0d of %0d.",
                 commands_taken, results_checked, peak_fill, idq_pkg::DEPTH);
        $display("Statuses: ok %0d, empty %0d, full %0d, out of range %0d; %0d mismatches.",
                 status_seen[idq_pkg::ST_OK], status_seen[idq_pkg::ST_EMPTY],
                 status_seen[idq_pkg::ST_FULL], status_seen[idq_pkg::ST_RANGE],
                 mismatch_count);
        if (mismatch_count == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial
    begin
        #20_000_000;
        $display("Timeout: %0d of %0d commands taken, %0d results outstanding",
                 commands_taken, commands_queued, predicted_results.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule

FILE: files.f
sv/idq_pkg.sv
sv/idq_ram.sv
sv/indexed_double_ended_queue_core.sv
test/tb_indexed_double_ended_queue_core.sv
